### rtl/lru_key_value_cache_unit_macros.svh
// ----------------------------------------------------------------------------
// lru key value cache assertion macros
// shared property forms for the cache checks, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH

// same-cycle implication
`define LKVC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lkvc check failed");

// next-cycle implication
`define LKVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lkvc check failed");

`endif

### rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// word types, opcodes and shift controls of the lru key value cache
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int OPCODE_W  = 2;
  localparam int KEY_W     = 64;
  localparam int VALUE_W   = 32;
  localparam int CFG_W     = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic [OPCODE_W-1:0] OP_GET = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SET = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DEL = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;

  localparam logic SRC_LEFT  = 1'b0;
  localparam logic SRC_RIGHT = 1'b1;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
    logic               evicted;
  } rsp_t;

  typedef struct packed {
    logic en;
    logic src;
  } shift_ctl_t;

endpackage

### rtl/lkvc_cell.sv
// ----------------------------------------------------------------------------
// lkvc_cell
// one entry of the recency-ordered chain: key compare and neighbor shift
// ----------------------------------------------------------------------------
module lkvc_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4,
  parameter int KB  = 64,
  parameter int VB  = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lkvc_pkg::shift_ctl_t ctl,
  input  logic [IW-1:0]        limit,
  input  logic [KB-1:0]        search_key,
  input  logic                 left_valid,
  input  logic [KB-1:0]        left_key,
  input  logic [VB-1:0]        left_value,
  input  logic                 right_valid,
  input  logic [KB-1:0]        right_key,
  input  logic [VB-1:0]        right_value,
  output logic                 ent_valid,
  output logic [KB-1:0]        ent_key,
  output logic [VB-1:0]        ent_value,
  output logic                 match
);

  logic take_left;
  logic take_right;

  assign take_left  = ctl.en && (ctl.src == lkvc_pkg::SRC_LEFT) && (IW'(IDX) <= limit);
  assign take_right = ctl.en && (ctl.src == lkvc_pkg::SRC_RIGHT) && (IW'(IDX) >= limit);
  assign match      = ent_valid && (ent_key == search_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (take_left) begin
      ent_valid <= left_valid;
    end else if (take_right) begin
      ent_valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_left) begin
      ent_key   <= left_key;
      ent_value <= left_value;
    end else if (take_right) begin
      ent_key   <= right_key;
      ent_value <= right_value;
    end
  end

endmodule

### rtl/lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// fully associative key value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// Entries sit in a chain of cells kept in recency order, most recent in cell
// zero, valid entries packed at the front. An accepted word goes through a
// match cycle that compares the key against every cell and reduces hit,
// position and value, then an update cycle that shifts the chain toward or
// away from the head in one step and loads the response register. The next
// word is taken during the update cycle of the last one while the response
// side keeps up; a stalled response holds the update cycle. Reset clears
// only the valid bits of the cells, there is no clearing pass.
module lru_key_value_cache_unit #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  lkvc_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output lkvc_pkg::rsp_t                rsp,
  input  logic                          wr_en,
  input  logic [lkvc_pkg::CFG_W-1:0]    wr_data
);

`include "lru_key_value_cache_unit_macros.svh"

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CAPW = (CW > lkvc_pkg::CFG_W) ? CW : lkvc_pkg::CFG_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MATCH  = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0]                    state;
  logic [1:0]                    state_next;
  logic [lkvc_pkg::OPCODE_W-1:0] op;
  logic [KEY_BITS-1:0]           pkey;
  logic [VALUE_BITS-1:0]         pvalue;
  logic                          mhit;
  logic [IW-1:0]                 midx;
  logic [VALUE_BITS-1:0]         mval;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 count_next;
  logic [lkvc_pkg::CFG_W-1:0]    cap_cfg;

  logic [CAPACITY-1:0]   cv;
  logic [KEY_BITS-1:0]   ck [CAPACITY];
  logic [VALUE_BITS-1:0] cval [CAPACITY];
  logic [CAPACITY-1:0]   cm;
  logic [CAPACITY-1:0]   lv;
  logic [KEY_BITS-1:0]   lk [CAPACITY];
  logic [VALUE_BITS-1:0] lval [CAPACITY];
  logic [CAPACITY-1:0]   rv;
  logic [KEY_BITS-1:0]   rk [CAPACITY];
  logic [VALUE_BITS-1:0] rval [CAPACITY];

  logic                  red_hit;
  logic [IW-1:0]         red_idx;
  logic [VALUE_BITS-1:0] red_val;

  lkvc_pkg::shift_ctl_t  ctl;
  logic [IW-1:0]         limit;
  logic [VALUE_BITS-1:0] head_value;
  logic [CAPW-1:0]       cap_eff;
  logic                  full;
  logic                  go;
  logic                  accept;
  lkvc_pkg::rsp_t        rsp_next;

  assign go        = (state == ST_UPDATE) && (!rsp_valid || rsp_ready);
  assign req_ready = (state == ST_IDLE) || go;
  assign accept    = req_valid && req_ready;

  always_comb begin
    if (cap_cfg == '0) begin
      cap_eff = CAPW'(1);
    end else if (CAPW'(cap_cfg) > CAPW'(CAPACITY)) begin
      cap_eff = CAPW'(CAPACITY);
    end else begin
      cap_eff = CAPW'(cap_cfg);
    end
  end

  assign full = CAPW'(count) >= cap_eff;

  // match reduction, keys are unique among valid cells
  always_comb begin
    red_idx = '0;
    red_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      red_idx = red_idx | ({IW{cm[i]}} & IW'(i));
      red_val = red_val | ({VALUE_BITS{cm[i]}} & cval[i]);
    end
    red_hit = |cm;
  end

  always_comb begin
    ctl        = '0;
    limit      = '0;
    head_value = pvalue;
    count_next = count;
    rsp_next   = '0;
    if (go) begin
      case (op)
        lkvc_pkg::OP_GET: begin
          rsp_next.hit = mhit;
          if (mhit) begin
            ctl.en              = 1'b1;
            ctl.src             = lkvc_pkg::SRC_LEFT;
            limit               = midx;
            head_value          = mval;
            rsp_next.read_value = lkvc_pkg::VALUE_W'(mval);
          end
        end
        lkvc_pkg::OP_SET: begin
          rsp_next.hit = mhit;
          ctl.en       = 1'b1;
          ctl.src      = lkvc_pkg::SRC_LEFT;
          if (mhit) begin
            limit = midx;
          end else if (full) begin
            limit            = IW'(count - CW'(1));
            rsp_next.evicted = 1'b1;
          end else begin
            limit      = IW'(count);
            count_next = count + CW'(1);
          end
        end
        lkvc_pkg::OP_DEL: begin
          rsp_next.hit = mhit;
          if (mhit) begin
            ctl.en     = 1'b1;
            ctl.src    = lkvc_pkg::SRC_RIGHT;
            limit      = midx;
            count_next = count - CW'(1);
          end
        end
        default: begin
          rsp_next = '0;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_MATCH;
        end
      end
      ST_MATCH: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (go) begin
          state_next = req_valid ? ST_MATCH : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      cap_cfg   <= lkvc_pkg::CFG_RESET;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (wr_en) begin
        cap_cfg <= wr_data;
      end
      if (go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= req.opcode;
      pkey   <= KEY_BITS'(req.key);
      pvalue <= VALUE_BITS'(req.value);
    end
    if (state == ST_MATCH) begin
      mhit <= red_hit;
      midx <= red_idx;
      mval <= red_val;
    end
    if (go) begin
      rsp <= rsp_next;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign lv[i]   = 1'b1;
      assign lk[i]   = pkey;
      assign lval[i] = head_value;
    end else begin : g_left
      assign lv[i]   = cv[i-1];
      assign lk[i]   = ck[i-1];
      assign lval[i] = cval[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign rv[i]   = 1'b0;
      assign rk[i]   = '0;
      assign rval[i] = '0;
    end else begin : g_right
      assign rv[i]   = cv[i+1];
      assign rk[i]   = ck[i+1];
      assign rval[i] = cval[i+1];
    end

    lkvc_cell #(
      .IDX (i),
      .IW  (IW),
      .KB  (KEY_BITS),
      .VB  (VALUE_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .limit       (limit),
      .search_key  (pkey),
      .left_valid  (lv[i]),
      .left_key    (lk[i]),
      .left_value  (lval[i]),
      .right_valid (rv[i]),
      .right_key   (rk[i]),
      .right_value (rval[i]),
      .ent_valid   (cv[i]),
      .ent_key     (ck[i]),
      .ent_value   (cval[i]),
      .match       (cm[i])
    );
  end

  `LKVC_ASSERT_NOW(a_count_matches_valid, 1'b1, $countones(cv) == int'(count))
  `LKVC_ASSERT_NEXT(a_accept_to_match, accept, state == ST_MATCH)
  `LKVC_ASSERT_NOW(a_evict_only_on_miss, rsp_valid && rsp.evicted, !rsp.hit)
  `LKVC_ASSERT_NEXT(a_insert_grows, go && (op == lkvc_pkg::OP_SET) && !mhit && !full,
                    count == $past(count) + CW'(1))

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives get, set, delete and no-op words into the lru key value cache under
// a range of capacities, mirrors the cache contents and recency order in a
// local predictor and checks every response word field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int LINES     = 16;
  localparam int PHASES    = 12;
  localparam int PHASE_LEN = 135;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    lkvc_pkg::req_t             w;
    bit                         typed;
    lkvc_pkg::rsp_t             want;
    logic [lkvc_pkg::CFG_W-1:0] cap;
  } row_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       req_valid;
  logic                       req_ready;
  lkvc_pkg::req_t             req;
  logic                       rsp_valid;
  logic                       rsp_ready;
  lkvc_pkg::rsp_t             rsp;
  logic                       wr_en;
  logic [lkvc_pkg::CFG_W-1:0] wr_data;

  logic [lkvc_pkg::KEY_W-1:0]   line_key[LINES];
  logic [lkvc_pkg::VALUE_W-1:0] line_val[LINES];
  bit                           line_live[LINES];
  int                           line_age[LINES];
  int                           cap_reg;

  lkvc_pkg::rsp_t pending_rsp[$];
  lkvc_pkg::rsp_t head_rsp;
  row_t           plan[$];
  int             errors    = 0;
  bit             tx_idle   = 1'b1;
  bit             rx_idle   = 1'b1;
  int             rx_hold   = 0;

  lru_key_value_cache_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .wr_en     (wr_en),
    .wr_data   (wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("lru_key_value_cache_unit test failed");
    $finish;
  end

  function automatic int clamp_cap(int c);
    if (c < 1) return 1;
    if (c > LINES) return LINES;
    return c;
  endfunction

  function automatic int find_line(logic [lkvc_pkg::KEY_W-1:0] k);
    for (int i = 0; i < LINES; i++)
      if (line_live[i] && line_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void promote(int e);
    int r;
    r = line_age[e];
    for (int i = 0; i < LINES; i++)
      if (line_live[i] && line_age[i] < r) line_age[i]++;
    line_age[e] = 0;
  endfunction

  function automatic void retire(int e);
    int r;
    r = line_age[e];
    line_live[e] = 1'b0;
    line_age[e]  = 0;
    for (int i = 0; i < LINES; i++)
      if (line_live[i] && line_age[i] > r) line_age[i]--;
  endfunction

  function automatic lkvc_pkg::rsp_t cache_predict(lkvc_pkg::req_t w);
    lkvc_pkg::rsp_t r;
    int             e;
    int             cnt;
    int             old;
    r = '0;
    e = find_line(w.key);
    case (w.opcode)
      lkvc_pkg::OP_GET: begin
        if (e >= 0) begin
          r.hit        = 1'b1;
          r.read_value = line_val[e];
          promote(e);
        end
      end
      lkvc_pkg::OP_SET: begin
        if (e >= 0) begin
          r.hit       = 1'b1;
          line_val[e] = w.value;
          promote(e);
        end else begin
          cnt = 0;
          for (int i = 0; i < LINES; i++)
            if (line_live[i]) cnt++;
          if (cnt >= clamp_cap(cap_reg)) begin
            old = -1;
            for (int i = 0; i < LINES; i++)
              if (line_live[i] && (old < 0 || line_age[i] > line_age[old])) old = i;
            if (old >= 0) begin
              retire(old);
              r.evicted = 1'b1;
            end
          end
          for (int i = 0; i < LINES; i++)
            if (line_live[i]) line_age[i]++;
          for (int i = 0; i < LINES; i++) begin
            if (!line_live[i]) begin
              line_live[i] = 1'b1;
              line_key[i]  = w.key;
              line_val[i]  = w.value;
              line_age[i]  = 0;
              break;
            end
          end
        end
      end
      lkvc_pkg::OP_DEL: begin
        if (e >= 0) begin
          r.hit = 1'b1;
          retire(e);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_word(logic [lkvc_pkg::OPCODE_W-1:0] op,
                                   logic [lkvc_pkg::KEY_W-1:0] k,
                                   logic [lkvc_pkg::VALUE_W-1:0] v, bit typed,
                                   lkvc_pkg::rsp_t want);
    row_t row;
    row.kind  = ROW_WORD;
    row.w     = '{opcode: op, key: k, value: v};
    row.typed = typed;
    row.want  = want;
    row.cap   = '0;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void add_cap(logic [lkvc_pkg::CFG_W-1:0] c);
    row_t row;
    row.kind  = ROW_CFG;
    row.w     = '0;
    row.typed = 1'b0;
    row.want  = '0;
    row.cap   = c;
    plan.insert(plan.size(), row);
  endfunction

  task automatic tx_gap();
    if (tx_idle)
      while ($urandom_range(99) < 33) begin
        @(negedge clk);
        req_valid <= 1'b0;
      end
  endtask

  task automatic put_word(lkvc_pkg::req_t w, bit typed, lkvc_pkg::rsp_t want);
    lkvc_pkg::rsp_t got;
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (!req_ready);
    got = cache_predict(w);
    pending_rsp.insert(pending_rsp.size(), typed ? want : got);
  endtask

  // config only once the cache has handed back every pending word
  task automatic write_cap(logic [lkvc_pkg::CFG_W-1:0] c);
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    wr_en   <= 1'b1;
    wr_data <= c;
    @(negedge clk);
    wr_en   <= 1'b0;
    cap_reg = int'(c);
  endtask

  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= !rx_idle || ($urandom_range(99) >= 33);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none actual %p", $time, rsp);
      end else begin
        head_rsp = pending_rsp.pop_front();
        if (rsp.hit !== head_rsp.hit) begin
          errors++;
          $display("%0t: hit expected %0b actual %0b", $time, head_rsp.hit, rsp.hit);
        end
        if (rsp.read_value !== head_rsp.read_value) begin
          errors++;
          $display("%0t: read_value expected %h actual %h", $time,
                   head_rsp.read_value, rsp.read_value);
        end
        if (rsp.evicted !== head_rsp.evicted) begin
          errors++;
          $display("%0t: evicted expected %0b actual %0b", $time,
                   head_rsp.evicted, rsp.evicted);
        end
      end
    end
  end

  initial begin
    logic [lkvc_pkg::CFG_W-1:0] phase_cap[PHASES];
    logic [lkvc_pkg::KEY_W-1:0] pool[$];
    logic [lkvc_pkg::CFG_W-1:0] c;
    lkvc_pkg::req_t             w;
    int                         n;
    int                         r;

    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    wr_en     = 1'b0;
    wr_data   = '0;
    cap_reg   = int'(lkvc_pkg::CFG_RESET);
    for (int i = 0; i < LINES; i++) begin
      line_key[i]  = '0;
      line_val[i]  = '0;
      line_live[i] = 1'b0;
      line_age[i]  = 0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_word(lkvc_pkg::OP_GET, '0, '0, 1, '0);
    add_word(lkvc_pkg::OP_DEL, '1, '0, 1, '0);
    add_word(lkvc_pkg::OP_NOP, '1, '1, 1, '0);
    add_word(lkvc_pkg::OP_SET, '0, '0, 1, '0);
    add_word(lkvc_pkg::OP_SET, '1, '1, 1, '0);
    add_word(lkvc_pkg::OP_GET, '1, '0, 1, lkvc_pkg::rsp_t'{1'b1, 32'hffff_ffff, 1'b0});
    add_word(lkvc_pkg::OP_GET, '0, '0, 1, lkvc_pkg::rsp_t'{1'b1, 32'h0, 1'b0});
    add_word(lkvc_pkg::OP_SET, '0, '1, 1, lkvc_pkg::rsp_t'{1'b1, 32'h0, 1'b0});
    add_word(lkvc_pkg::OP_GET, '0, '0, 1, lkvc_pkg::rsp_t'{1'b1, 32'hffff_ffff, 1'b0});
    add_word(lkvc_pkg::OP_DEL, '0, '0, 1, lkvc_pkg::rsp_t'{1'b1, 32'h0, 1'b0});
    add_word(lkvc_pkg::OP_GET, '0, '0, 1, '0);
    add_word(lkvc_pkg::OP_SET, 64'h8000_0000_0000_0000, 32'h8000_0000, 0, '0);
    add_word(lkvc_pkg::OP_SET, 64'h1, 32'h1, 0, '0);
    add_word(lkvc_pkg::OP_NOP, 64'h1, 32'h1, 1, '0);
    add_word(lkvc_pkg::OP_GET, 64'h8000_0000_0000_0000, '0, 0, '0);
    // capacity dropped below the live count
    add_cap(5'd1);
    add_word(lkvc_pkg::OP_SET, 64'h5555_5555_5555_5555, 32'h5555_5555, 0, '0);
    add_word(lkvc_pkg::OP_GET, 64'h1, '0, 0, '0);
    // zero and oversize capacity clamp
    add_cap(5'd0);
    add_word(lkvc_pkg::OP_SET, 64'haaaa_aaaa_aaaa_aaaa, 32'haaaa_aaaa, 0, '0);
    add_word(lkvc_pkg::OP_GET, 64'haaaa_aaaa_aaaa_aaaa, '0, 0, '0);
    add_cap(5'd31);
    add_word(lkvc_pkg::OP_SET, 64'h0123_4567_89ab_cdef, 32'h89ab_cdef, 0, '0);
    add_word(lkvc_pkg::OP_DEL, '1, '0, 0, '0);
    add_word(lkvc_pkg::OP_GET, '1, '0, 1, '0);
    add_cap(5'd16);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_cap(plan[i].cap);
      end else begin
        tx_gap();
        put_word(plan[i].w, plan[i].typed, plan[i].want);
      end
    end

    phase_cap = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd2, 5'd16, 5'd8, 5'd3, 5'd15,
                  5'd0, 5'd0};
    phase_cap[10] = 5'($urandom_range(31));
    phase_cap[11] = 5'($urandom_range(31));

    for (int p = 0; p < PHASES; p++) begin
      c = phase_cap[p];
      write_cap(c);
      tx_idle = (p != 3) && (p != 5);
      rx_idle = (p != 3);
      // long response stall while the sender keeps pushing
      if (p == 5) rx_hold = 150;

      n = clamp_cap(int'(c)) + int'($urandom_range(1, 8));
      pool.delete();
      for (int j = 0; j < n; j++) begin
        r = int'($urandom_range(9));
        if (r == 0) pool.insert(pool.size(), '0);
        else if (r == 1) pool.insert(pool.size(), '1);
        else pool.insert(pool.size(), {$urandom, $urandom});
      end

      for (int j = 0; j < PHASE_LEN; j++) begin
        r = int'($urandom_range(99));
        if (r < 40) w.opcode = lkvc_pkg::OP_GET;
        else if (r < 75) w.opcode = lkvc_pkg::OP_SET;
        else if (r < 93) w.opcode = lkvc_pkg::OP_DEL;
        else w.opcode = lkvc_pkg::OP_NOP;
        if ($urandom_range(9) == 0) w.key = {$urandom, $urandom};
        else w.key = pool[$urandom_range(n - 1)];
        w.value = $urandom;
        tx_gap();
        put_word(w, 0, '0);
      end
    end

    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0 && pending_rsp.size() == 0)
      $display("lru_key_value_cache_unit test passed");
    else
      $display("lru_key_value_cache_unit test failed");
    $finish;
  end

endmodule
